// File: hw/rtl/wspc_pkg.sv
// wspc_pkg: shared types and constants for the wheel speed PI controller.
// Used by wspc_engine and wheel_speed_pi_controller. No dependencies.
package wspc_pkg;

    // APB address width: five 32-bit registers at 4-byte spacing
    localparam int PADDR_W = 5;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        IDX_TICKS_PER_MM  = 3'd0,
        IDX_PROP_GAIN     = 3'd1,
        IDX_INTEGRAL_GAIN = 3'd2,
        IDX_DUTY_LIMIT    = 3'd3,
        IDX_ERROR_LIMIT   = 3'd4
    } reg_idx_t;

    // Register reset values
    localparam logic [23:0] TPM_RST   = 24'd65536;
    localparam logic [15:0] PGAIN_RST = 16'd49152;
    localparam logic [15:0] IGAIN_RST = 16'd16384;
    localparam logic [15:0] DLIM_RST  = 16'd39322;
    localparam logic [30:0] ELIM_RST  = 31'd655360;

    // Bit-serial pass lengths (one bit per cycle)
    localparam int MUL1_STEPS = 16;   // speed magnitude bits
    localparam int MUL2_STEPS = 24;   // elapsed_ns bits
    localparam int DIV_STEPS  = 26;   // quotient bits, target < 2^26
    localparam int MUL3_STEPS = 16;   // gain bits
    localparam int CNT_W      = 5;

    // target = (prod + 1.28e11) / 2.56e11
    localparam logic [38:0] DIV_CONST = 39'd256000000000;
    localparam logic [63:0] RND_HALF  = 64'd128000000000;

    typedef struct packed {
        logic [23:0] ticks_per_mm;
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
        logic [15:0] duty_limit;
        logic [30:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic        start;      // input beat accepted this cycle
        logic        res_take;   // result moves to the output register
    } eng_ctl_t;

    typedef struct packed {
        logic        idle;
        logic        res_valid;
    } eng_sts_t;

    typedef struct packed {
        logic [15:0] duty_magnitude;
        logic        reverse;
        logic [31:0] odometry_count;
        logic [31:0] accumulated_error;
        logic        limit_exceeded;
    } res_t;

endpackage

// File: hw/rtl/wspc_engine.sv
// wspc_engine: bit-serial arithmetic sequencer of the wheel speed PI controller.
// Holds the integral and odometry state. Depends on wspc_pkg.
module wspc_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wspc_pkg::cfg_t       cfg,
    input  wspc_pkg::eng_ctl_t   ctl,
    output wspc_pkg::eng_sts_t   sts,
    input  logic signed [15:0]   in_ticks,
    input  logic        [23:0]   in_ns,
    input  logic signed [15:0]   in_speed,
    input  logic                 in_taken,
    output wspc_pkg::res_t       res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_RND, ST_DIV, ST_ERR,
        ST_INTEG, ST_MUL3, ST_MAG, ST_DUTY, ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [wspc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [15:0]                  ticks_reg, ticks_next;
    logic                         sneg_reg, sneg_next;
    logic [39:0]                  m1_reg, m1_next;
    logic [63:0]                  w_reg, w_next;
    logic [38:0]                  rem_reg, rem_next;
    logic [25:0]                  quo_reg, quo_next;
    logic [33:0]                  err_reg, err_next;
    logic [31:0]                  integ_reg, integ_next;
    logic [31:0]                  odo_reg, odo_next;
    logic [36:0]                  hi_reg, hi_next;
    logic [15:0]                  lo_reg, lo_next;
    logic [15:0]                  pg_reg, pg_next;
    logic [15:0]                  ig_reg, ig_next;
    logic [52:0]                  mag_reg, mag_next;
    logic                         rev_reg, rev_next;
    logic [15:0]                  duty_reg, duty_next;
    logic                         over_reg, over_next;

    always_comb begin
        logic [24:0] m1_sum;
        logic [40:0] w_sum;
        logic [63:0] rnd;
        logic [38:0] div_t;
        logic        div_ge;
        logic [33:0] tgt;
        logic [34:0] acc_wide;
        logic [36:0] add_e;
        logic [36:0] add_a;
        logic [36:0] hi_sum;
        logic [52:0] sum_full;
        logic [38:0] rnd_duty;
        logic [37:0] duty_wide;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        ticks_next = ticks_reg;
        sneg_next  = sneg_reg;
        m1_next    = m1_reg;
        w_next     = w_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        err_next   = err_reg;
        integ_next = integ_reg;
        odo_next   = odo_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        pg_next    = pg_reg;
        ig_next    = ig_reg;
        mag_next   = mag_reg;
        rev_next   = rev_reg;
        duty_next  = duty_reg;
        over_next  = over_reg;

        // shift-add step of speed * ticks_per_mm (right-shifting product)
        m1_sum = {1'b0, m1_reg[39:16]} + {1'b0, cfg.ticks_per_mm};
        // shift-add step of (speed * tpm) * elapsed_ns
        w_sum  = {1'b0, w_reg[63:24]} + {1'b0, m1_reg};
        rnd    = w_reg + wspc_pkg::RND_HALF;
        // restoring division by the time/scale constant
        div_t  = {rem_reg[37:0], quo_reg[25]};
        div_ge = (div_t >= wspc_pkg::DIV_CONST);
        // signed target and tick error in Q16.16
        tgt = {8'd0, quo_reg};
        if (sneg_reg) begin
            tgt = ~tgt + 34'd1;
        end
        acc_wide = {{3{integ_reg[31]}}, integ_reg} + {err_reg[33], err_reg};
        // gains times error and integral, one gain bit per cycle
        add_e  = pg_reg[0] ? {{3{err_reg[33]}}, err_reg} : 37'd0;
        add_a  = ig_reg[0] ? {{5{integ_reg[31]}}, integ_reg} : 37'd0;
        hi_sum = hi_reg + add_e + add_a;
        sum_full = {hi_reg, lo_reg};
        // round to Q0.16: (mag + 2^15) >> 16
        rnd_duty  = {1'b0, mag_reg[52:15]} + 39'd1;
        duty_wide = rnd_duty[38:1];

        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.start) begin
                    ticks_next = in_ticks;
                    sneg_next  = in_speed[15];
                    m1_next    = {24'd0, (in_speed[15] ? 16'(-in_speed) : in_speed)};
                    w_next     = {40'd0, in_ns};
                    pg_next    = cfg.prop_gain;
                    ig_next    = cfg.integral_gain;
                    cnt_next   = '0;
                    if (in_taken) begin
                        odo_next = {{16{in_ticks[15]}}, in_ticks};
                    end else begin
                        odo_next = odo_reg + {{16{in_ticks[15]}}, in_ticks};
                    end
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (m1_reg[0]) begin
                    m1_next = {m1_sum, m1_reg[15:1]};
                end else begin
                    m1_next = {1'b0, m1_reg[39:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wspc_pkg::CNT_W'(wspc_pkg::MUL1_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (w_reg[0]) begin
                    w_next = {w_sum, w_reg[23:1]};
                end else begin
                    w_next = {1'b0, w_reg[63:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wspc_pkg::CNT_W'(wspc_pkg::MUL2_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                rem_next   = {1'b0, rnd[63:26]};
                quo_next   = rnd[25:0];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = div_ge ? (div_t - wspc_pkg::DIV_CONST) : div_t;
                quo_next = {quo_reg[24:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wspc_pkg::CNT_W'(wspc_pkg::DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = tgt - {{2{ticks_reg[15]}}, ticks_reg, 16'd0};
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                // saturate to signed 32 bits
                if (!acc_wide[34] && (acc_wide[33:31] != 3'b000)) begin
                    integ_next = 32'h7FFF_FFFF;
                end else if (acc_wide[34] && (acc_wide[33:31] != 3'b111)) begin
                    integ_next = 32'h8000_0000;
                end else begin
                    integ_next = acc_wide[31:0];
                end
                hi_next    = '0;
                lo_next    = '0;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                hi_next  = {hi_sum[36], hi_sum[36:1]};
                lo_next  = {hi_sum[0], lo_reg[15:1]};
                pg_next  = {1'b0, pg_reg[15:1]};
                ig_next  = {1'b0, ig_reg[15:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == wspc_pkg::CNT_W'(wspc_pkg::MUL3_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                rev_next   = hi_reg[36];
                mag_next   = hi_reg[36] ? (~sum_full + 53'd1) : sum_full;
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                if (duty_wide > {22'd0, cfg.duty_limit}) begin
                    duty_next = cfg.duty_limit;
                end else begin
                    duty_next = duty_wide[15:0];
                end
                over_next  = !integ_reg[31] && (integ_reg[30:0] > cfg.error_limit);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (ctl.res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counters and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            integ_reg <= '0;
            odo_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            integ_reg <= integ_next;
            odo_reg   <= odo_next;
        end
        ticks_reg <= ticks_next;
        sneg_reg  <= sneg_next;
        m1_reg    <= m1_next;
        w_reg     <= w_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        err_reg   <= err_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        pg_reg    <= pg_next;
        ig_reg    <= ig_next;
        mag_reg   <= mag_next;
        rev_reg   <= rev_next;
        duty_reg  <= duty_next;
        over_reg  <= over_next;
    end

    assign sts.idle      = (state_reg == ST_IDLE);
    assign sts.res_valid = (state_reg == ST_DONE);

    assign res.duty_magnitude    = duty_reg;
    assign res.reverse           = rev_reg;
    assign res.odometry_count    = odo_reg;
    assign res.accumulated_error = integ_reg;
    assign res.limit_exceeded    = over_reg;

    // a new beat only starts an idle engine
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> (state_reg == ST_IDLE))
        else $error("start while engine busy");

    // division remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < wspc_pkg::DIV_CONST))
        else $error("divider remainder out of range");

    // finished duty respects the clamp
    a_duty_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.res_valid |-> (duty_reg <= cfg.duty_limit))
        else $error("duty above limit");

    // step counter never passes the longest pass
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < wspc_pkg::CNT_W'(wspc_pkg::DIV_STEPS))
        else $error("step counter out of range");

endmodule

// File: hw/rtl/wheel_speed_pi_controller.sv
// wheel_speed_pi_controller: top level with APB registers and result register.
// Depends on wspc_pkg and wspc_engine.
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid / s_ready  measured_ticks, elapsed_ns, speed_target,
//                                          odometry_taken
//  m_*       out        m_valid / m_ready  duty_magnitude, reverse, odometry_count,
//                                          accumulated_error, limit_exceeded
//  apb       in         psel/penable       5 registers at paddr 0x00..0x10
//
// Each beat runs through the bit-serial passes (16 + 24 multiply bits, 26 divide
// bits, 16 gain bits) of the shared engine before its result is in the output
// register; a new beat is taken only once the engine has handed that result on.
// Reset (aresetn low, synchronous) clears the integral and odometry count and sets the regs to their reset values.
// A result waiting on m_ready does not block the next beat; the engine holds
// its following result until the output register frees.
module wheel_speed_pi_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wspc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_measured_ticks,
    input  logic        [23:0]            s_elapsed_ns,
    input  logic signed [15:0]            s_speed_target,
    input  logic                          s_odometry_taken,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [15:0]            m_duty_magnitude,
    output logic                          m_reverse,
    output logic signed [31:0]            m_odometry_count,
    output logic signed [31:0]            m_accumulated_error,
    output logic                          m_limit_exceeded
);

    wspc_pkg::cfg_t      cfg_reg, cfg_next;
    wspc_pkg::eng_ctl_t  eng_ctl;
    wspc_pkg::eng_sts_t  eng_sts;
    wspc_pkg::res_t      eng_res;
    wspc_pkg::res_t      out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic                cfg_wr;
    wspc_pkg::reg_idx_t  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = wspc_pkg::reg_idx_t'(paddr[4:2]);

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                wspc_pkg::IDX_TICKS_PER_MM:  cfg_next.ticks_per_mm  = pwdata[23:0];
                wspc_pkg::IDX_PROP_GAIN:     cfg_next.prop_gain     = pwdata[15:0];
                wspc_pkg::IDX_INTEGRAL_GAIN: cfg_next.integral_gain = pwdata[15:0];
                wspc_pkg::IDX_DUTY_LIMIT:    cfg_next.duty_limit    = pwdata[15:0];
                wspc_pkg::IDX_ERROR_LIMIT:   cfg_next.error_limit   = pwdata[30:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_idx)
            wspc_pkg::IDX_TICKS_PER_MM:  prdata = {8'd0, cfg_reg.ticks_per_mm};
            wspc_pkg::IDX_PROP_GAIN:     prdata = {16'd0, cfg_reg.prop_gain};
            wspc_pkg::IDX_INTEGRAL_GAIN: prdata = {16'd0, cfg_reg.integral_gain};
            wspc_pkg::IDX_DUTY_LIMIT:    prdata = {16'd0, cfg_reg.duty_limit};
            wspc_pkg::IDX_ERROR_LIMIT:   prdata = {1'b0, cfg_reg.error_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    // handshake to the engine
    assign s_ready          = eng_sts.idle;
    assign eng_ctl.start    = s_valid && eng_sts.idle;
    assign eng_ctl.res_take = eng_sts.res_valid && (!m_valid_reg || m_ready);

    wspc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ctl      (eng_ctl),
        .sts      (eng_sts),
        .in_ticks (s_measured_ticks),
        .in_ns    (s_elapsed_ns),
        .in_speed (s_speed_target),
        .in_taken (s_odometry_taken),
        .res      (eng_res)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eng_ctl.res_take) begin
            m_valid_next = 1'b1;
            out_next     = eng_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_mm  <= wspc_pkg::TPM_RST;
            cfg_reg.prop_gain     <= wspc_pkg::PGAIN_RST;
            cfg_reg.integral_gain <= wspc_pkg::IGAIN_RST;
            cfg_reg.duty_limit    <= wspc_pkg::DLIM_RST;
            cfg_reg.error_limit   <= wspc_pkg::ELIM_RST;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_duty_magnitude    = out_reg.duty_magnitude;
    assign m_reverse           = out_reg.reverse;
    assign m_odometry_count    = out_reg.odometry_count;
    assign m_accumulated_error = out_reg.accumulated_error;
    assign m_limit_exceeded    = out_reg.limit_exceeded;

endmodule
